### design/u64ht_pkg.sv
// Shared constants, codes and state types for the 64-bit key hash table.
`timescale 1ns / 1ps
package u64ht_pkg;

    localparam int MAX_BUCKETS_DEF = 256;
    localparam int POOL_NODES_DEF  = 1024;
    localparam int VALUE_BITS_DEF  = 32;

    localparam int KEY_W  = 64;
    localparam int VAL_W  = 32;
    localparam int CFG_W  = 9;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 9'd256;

    // key is reduced modulo the bucket count a byte per cycle
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = KEY_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_NEW    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FOUND  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_HEAD,
        B_NODE,
        B_EXEC,
        B_ALLOC,
        B_LINK,
        B_RESP
    } back_state_t;

endpackage

### design/u64_key_hash_table_core.sv
// Top level of the 64-bit key hash table with sorted chains.
//
// Requests (action, key, value) enter on the s_ channel; each gives exactly
// one response (status, result_value) on the m_ channel, in request order.
// Actions: insert, lookup, delete. The bucket is key modulo bucket_count,
// written on the cfg_ channel (always ready); the user must write it only
// while the table is idle, as the block itself does not enforce it.
// The front end takes a request and reduces the key a byte per cycle; it
// takes no new request until it has handed the last one to the queue.
// A two-entry queue feeds the chain engine, which walks a chain one node per
// cycle (bound by the node RAM read latency), then relinks an insert in the
// B_ALLOC and B_LINK states or a delete in the B_EXEC and B_LINK states.
// After reset the engine clears the bucket heads, one per cycle, and s_ready
// stays low until it is done. The response sits in an output register;
// while m_ready is low the engine waits in B_RESP and the front end keeps
// working until the queue fills, then s_ready stays low.
`timescale 1ns / 1ps
module u64_key_hash_table_core #(
    parameter int MAX_BUCKETS = u64ht_pkg::MAX_BUCKETS_DEF,
    parameter int POOL_NODES  = u64ht_pkg::POOL_NODES_DEF,
    parameter int VALUE_BITS  = u64ht_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [u64ht_pkg::CFG_W-1:0]   cfg_bucket_count,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [u64ht_pkg::ACT_W-1:0]   s_action,
    input  logic [u64ht_pkg::KEY_W-1:0]   s_key,
    input  logic [u64ht_pkg::VAL_W-1:0]   s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [u64ht_pkg::STAT_W-1:0]  m_status,
    output logic [u64ht_pkg::VAL_W-1:0]   m_result_value
);
    import u64ht_pkg::*;

    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int QW = ACT_W + KEY_W + VAL_W + BW;

    logic              init_done;
    logic              f_valid, f_ready, b_valid, b_ready;
    logic [ACT_W-1:0]  f_action, b_action;
    logic [KEY_W-1:0]  f_key, b_key;
    logic [VAL_W-1:0]  f_value, b_value;
    logic [BW-1:0]     f_bucket, b_bucket;
    logic [QW-1:0]     q_in, q_out;

    assign q_in = {f_action, f_key, f_value, f_bucket};
    assign {b_action, b_key, b_value, b_bucket} = q_out;

    u64ht_front #(.MAX_BUCKETS(MAX_BUCKETS)) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_bucket_count (cfg_bucket_count),
        .enable           (init_done),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_key            (s_key),
        .s_value          (s_value),
        .q_valid          (f_valid),
        .q_ready          (f_ready),
        .q_action         (f_action),
        .q_key            (f_key),
        .q_value          (f_value),
        .q_bucket         (f_bucket)
    );

    u64ht_queue #(.W(QW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (q_in),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (q_out)
    );

    u64ht_back #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .POOL_NODES  (POOL_NODES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .init_done      (init_done),
        .q_valid        (b_valid),
        .q_ready        (b_ready),
        .q_action       (b_action),
        .q_key          (b_key),
        .q_value        (b_value),
        .q_bucket       (b_bucket),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_result_value (m_result_value)
    );

endmodule

### design/u64ht_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module u64ht_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/u64ht_front.sv
// Front end: config register, request intake and key modulo bucket count.
`timescale 1ns / 1ps
module u64ht_front #(
    parameter int MAX_BUCKETS = 256,
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [u64ht_pkg::CFG_W-1:0]  cfg_bucket_count,
    input  logic                         enable,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [u64ht_pkg::ACT_W-1:0]  s_action,
    input  logic [u64ht_pkg::KEY_W-1:0]  s_key,
    input  logic [u64ht_pkg::VAL_W-1:0]  s_value,
    output logic                         q_valid,
    input  logic                         q_ready,
    output logic [u64ht_pkg::ACT_W-1:0]  q_action,
    output logic [u64ht_pkg::KEY_W-1:0]  q_key,
    output logic [u64ht_pkg::VAL_W-1:0]  q_value,
    output logic [BW-1:0]                q_bucket
);
    import u64ht_pkg::*;

    localparam int NW = $clog2(MAX_BUCKETS + 1);

    front_state_t       state_reg, state_next;
    logic [CFG_W-1:0]   bc_reg;
    logic [ACT_W-1:0]   act_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   sh_reg, sh_next;
    logic [VAL_W-1:0]   val_reg;
    logic [NW-1:0]      n_reg, n_eff;
    logic [NW-1:0]      rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [NW:0]        trial;
    logic               accept;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // zero acts as one, anything above the table size as the table size
    always_comb begin
        if (bc_reg == '0) begin
            n_eff = NW'(1);
        end else if ({23'd0, bc_reg} > 32'(MAX_BUCKETS)) begin
            n_eff = NW'(MAX_BUCKETS);
        end else begin
            n_eff = NW'(bc_reg);
        end
    end

    // one byte of restoring division per cycle
    always_comb begin
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {rem_next, sh_reg[KEY_W-1-i]};
            if (trial >= {1'b0, n_reg}) begin
                trial = trial - {1'b0, n_reg};
            end
            rem_next = trial[NW-1:0];
        end
        sh_next   = sh_reg << DIV_BITS;
        step_next = step_reg + 1'b1;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) state_next = F_DIV;
            end
            F_DIV: begin
                if (step_reg == STEP_W'(DIV_STEPS - 1)) state_next = F_PUSH;
            end
            F_PUSH: begin
                if (q_ready) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = (state_reg == F_IDLE) && enable;
        q_valid  = (state_reg == F_PUSH);
        q_action = act_reg;
        q_key    = key_reg;
        q_value  = val_reg;
        q_bucket = rem_reg[BW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            bc_reg    <= BUCKET_COUNT_RST;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                bc_reg <= cfg_bucket_count;
            end
            if (accept) begin
                step_reg <= '0;
            end else if (state_reg == F_DIV) begin
                step_reg <= step_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg <= s_action;
            key_reg <= s_key;
            sh_reg  <= s_key;
            val_reg <= s_value;
            n_reg   <= n_eff;
            rem_reg <= '0;
        end else if (state_reg == F_DIV) begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

endmodule

### design/u64ht_queue.sv
// Two-entry request queue between front end and chain engine.
`timescale 1ns / 1ps
module u64ht_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic [W-1:0] slot_reg [2];
    logic         wptr_reg, rptr_reg;
    logic [1:0]   cnt_reg, cnt_next;
    logic         push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= in_data;
        end
    end

endmodule

### design/u64ht_back.sv
// Chain engine: clears the bucket heads after reset, then walks a sorted bucket chain and carries out each request.
`timescale 1ns / 1ps
module u64ht_back #(
    parameter int MAX_BUCKETS = 256,
    parameter int POOL_NODES  = 1024,
    parameter int VALUE_BITS  = 32,
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    output logic                          init_done,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [u64ht_pkg::ACT_W-1:0]   q_action,
    input  logic [u64ht_pkg::KEY_W-1:0]   q_key,
    input  logic [u64ht_pkg::VAL_W-1:0]   q_value,
    input  logic [BW-1:0]                 q_bucket,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [u64ht_pkg::STAT_W-1:0]  m_status,
    output logic [u64ht_pkg::VAL_W-1:0]   m_result_value
);
    import u64ht_pkg::*;

    localparam int LW  = $clog2(POOL_NODES + 1);
    localparam int NAW = $clog2(POOL_NODES);
    localparam logic [LW-1:0] NULL_IDX = LW'(POOL_NODES);

    back_state_t             state_reg, state_next;
    logic [BW-1:0]           clr_cnt_reg;
    logic [ACT_W-1:0]        act_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [VALUE_BITS-1:0]   val_reg;
    logic [BW-1:0]           bkt_reg;
    logic [LW-1:0]           cur_reg, cur_next;
    logic [LW-1:0]           prev_reg, prev_next;
    logic                    hit_reg, hit_next;
    logic [VALUE_BITS-1:0]   nv_reg, nv_next;
    logic [LW-1:0]           nl_reg, nl_next;
    logic [LW-1:0]           lt_reg, lt_next;
    logic [LW-1:0]           fh_reg, fh_next;
    logic [LW-1:0]           bump_reg, bump_next;
    logic [STAT_W-1:0]       rs_reg, rs_next;
    logic [VALUE_BITS-1:0]   rv_reg, rv_next;
    logic                    m_valid_reg;
    logic [STAT_W-1:0]       m_status_reg;
    logic [VAL_W-1:0]        m_value_reg;
    logic                    slot_free, key_eq, key_lt, prev_null;

    logic                    hd_we;
    logic [BW-1:0]           hd_waddr;
    logic [LW-1:0]           hd_wdata, hd_rdata;
    logic                    nd_key_we, nd_val_we, nd_lnk_we;
    logic [LW-1:0]           nd_key_wa, nd_val_wa, nd_lnk_wa, nd_ra;
    logic [VALUE_BITS-1:0]   nd_val_wd, nd_val_rd;
    logic [LW-1:0]           nd_lnk_wd, nd_lnk_rd;
    logic [KEY_W-1:0]        nd_key_rd;

    assign slot_free = !m_valid_reg || m_ready;
    assign key_eq    = (nd_key_rd == key_reg);
    assign key_lt    = (key_reg < nd_key_rd);
    assign prev_null = (prev_reg >= NULL_IDX);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR: begin
                if (clr_cnt_reg == BW'(MAX_BUCKETS - 1)) state_next = B_IDLE;
            end
            B_IDLE: begin
                if (q_valid) state_next = B_HEAD;
            end
            B_HEAD: begin
                state_next = (hd_rdata >= NULL_IDX) ? B_EXEC : B_NODE;
            end
            B_NODE: begin
                if (key_eq || key_lt || nd_lnk_rd >= NULL_IDX) state_next = B_EXEC;
            end
            B_EXEC: begin
                case (act_reg)
                    ACT_INSERT: begin
                        state_next = (!hit_reg && fh_reg < NULL_IDX) ? B_ALLOC : B_RESP;
                    end
                    ACT_DELETE: begin
                        state_next = (hit_reg && !prev_null) ? B_LINK : B_RESP;
                    end
                    default: state_next = B_RESP;
                endcase
            end
            B_ALLOC: state_next = prev_null ? B_RESP : B_LINK;
            B_LINK:  state_next = B_RESP;
            B_RESP: begin
                if (slot_free) state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        cur_next  = cur_reg;
        prev_next = prev_reg;
        hit_next  = hit_reg;
        nv_next   = nv_reg;
        nl_next   = nl_reg;
        lt_next   = lt_reg;
        fh_next   = fh_reg;
        bump_next = bump_reg;
        rs_next   = rs_reg;
        rv_next   = rv_reg;
        case (state_reg)
            B_HEAD: begin
                prev_next = NULL_IDX;
                hit_next  = 1'b0;
                cur_next  = (hd_rdata >= NULL_IDX) ? NULL_IDX : hd_rdata;
            end
            B_NODE: begin
                if (key_eq) begin
                    hit_next = 1'b1;
                    nv_next  = nd_val_rd;
                    nl_next  = nd_lnk_rd;
                end else if (!key_lt) begin
                    prev_next = cur_reg;
                    cur_next  = (nd_lnk_rd >= NULL_IDX) ? NULL_IDX : nd_lnk_rd;
                end
            end
            B_EXEC: begin
                rs_next = ST_ABSENT;
                rv_next = '0;
                case (act_reg)
                    ACT_INSERT: begin
                        if (hit_reg) begin
                            rs_next = ST_FOUND;
                            rv_next = nv_reg;
                        end else if (fh_reg >= NULL_IDX) begin
                            rs_next = ST_FULL;
                        end
                    end
                    ACT_LOOKUP: begin
                        if (hit_reg) begin
                            rs_next = ST_FOUND;
                            rv_next = nv_reg;
                        end
                    end
                    ACT_DELETE: begin
                        if (hit_reg) begin
                            rs_next = ST_FOUND;
                            rv_next = nv_reg;
                            fh_next = cur_reg;
                            lt_next = nl_reg;
                        end
                    end
                    default: begin
                        rs_next = ST_ABSENT;
                    end
                endcase
            end
            B_ALLOC: begin
                rs_next = ST_NEW;
                rv_next = val_reg;
                lt_next = fh_reg;
                // a node at the bump mark has never been linked, its successor is implied
                if (fh_reg == bump_reg) begin
                    fh_next   = bump_reg + 1'b1;
                    bump_next = bump_reg + 1'b1;
                end else begin
                    fh_next = nd_lnk_rd;
                end
            end
            default: begin
                cur_next = cur_reg;
            end
        endcase
    end

    // memory port control and handshake outputs
    always_comb begin
        init_done = (state_reg != B_CLEAR);
        q_ready   = (state_reg == B_IDLE);
        hd_we     = 1'b0;
        hd_waddr  = bkt_reg;
        hd_wdata  = NULL_IDX;
        nd_key_we = 1'b0;
        nd_key_wa = fh_reg;
        nd_val_we = 1'b0;
        nd_val_wa = fh_reg;
        nd_val_wd = val_reg;
        nd_lnk_we = 1'b0;
        nd_lnk_wa = fh_reg;
        nd_lnk_wd = cur_reg;
        case (state_reg)
            B_HEAD:  nd_ra = hd_rdata;
            B_NODE:  nd_ra = nd_lnk_rd;
            default: nd_ra = fh_reg;
        endcase
        case (state_reg)
            B_CLEAR: begin
                hd_we    = 1'b1;
                hd_waddr = clr_cnt_reg;
            end
            B_EXEC: begin
                if (act_reg == ACT_INSERT && hit_reg) begin
                    nd_val_we = 1'b1;
                    nd_val_wa = cur_reg;
                end
                if (act_reg == ACT_DELETE && hit_reg) begin
                    nd_lnk_we = 1'b1;
                    nd_lnk_wa = cur_reg;
                    nd_lnk_wd = fh_reg;
                    hd_we     = prev_null;
                    hd_wdata  = nl_reg;
                end
            end
            B_ALLOC: begin
                nd_key_we = 1'b1;
                nd_val_we = 1'b1;
                nd_lnk_we = 1'b1;
                hd_we     = prev_null;
                hd_wdata  = fh_reg;
            end
            B_LINK: begin
                nd_lnk_we = 1'b1;
                nd_lnk_wa = prev_reg;
                nd_lnk_wd = lt_reg;
            end
            default: begin
                hd_we = 1'b0;
            end
        endcase
        m_valid        = m_valid_reg;
        m_status       = m_status_reg;
        m_result_value = m_value_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            clr_cnt_reg <= '0;
            fh_reg      <= '0;
            bump_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fh_reg    <= fh_next;
            bump_reg  <= bump_next;
            if (state_reg == B_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == B_RESP && slot_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_IDLE && q_valid) begin
            act_reg <= q_action;
            key_reg <= q_key;
            val_reg <= VALUE_BITS'(q_value);
            bkt_reg <= q_bucket;
        end
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        hit_reg  <= hit_next;
        nv_reg   <= nv_next;
        nl_reg   <= nl_next;
        lt_reg   <= lt_next;
        rs_reg   <= rs_next;
        rv_reg   <= rv_next;
        if (state_reg == B_RESP && slot_free) begin
            m_status_reg <= rs_reg;
            m_value_reg  <= VAL_W'(rv_reg);
        end
    end

    u64ht_ram #(.W(LW), .D(MAX_BUCKETS)) u_heads (
        .aclk  (aclk),
        .we    (hd_we),
        .waddr (hd_waddr),
        .wdata (hd_wdata),
        .raddr (q_bucket),
        .rdata (hd_rdata)
    );

    u64ht_ram #(.W(KEY_W), .D(POOL_NODES)) u_keys (
        .aclk  (aclk),
        .we    (nd_key_we),
        .waddr (nd_key_wa[NAW-1:0]),
        .wdata (key_reg),
        .raddr (nd_ra[NAW-1:0]),
        .rdata (nd_key_rd)
    );

    u64ht_ram #(.W(VALUE_BITS), .D(POOL_NODES)) u_vals (
        .aclk  (aclk),
        .we    (nd_val_we),
        .waddr (nd_val_wa[NAW-1:0]),
        .wdata (nd_val_wd),
        .raddr (nd_ra[NAW-1:0]),
        .rdata (nd_val_rd)
    );

    u64ht_ram #(.W(LW), .D(POOL_NODES)) u_links (
        .aclk  (aclk),
        .we    (nd_lnk_we),
        .waddr (nd_lnk_wa[NAW-1:0]),
        .wdata (nd_lnk_wd),
        .raddr (nd_ra[NAW-1:0]),
        .rdata (nd_lnk_rd)
    );

endmodule

### design/u64ht_checker.sv
// Port-level checks for the hash table top level, bound onto it.
`timescale 1ns / 1ps
module u64ht_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [u64ht_pkg::STAT_W-1:0]  m_status,
    input logic [u64ht_pkg::VAL_W-1:0]   m_result_value
);
    import u64ht_pkg::*;

    logic [3:0] pend_reg;
    logic       in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // requests taken but not yet answered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else if (in_acc && !out_acc) begin
            pend_reg <= pend_reg + 4'd1;
        end else if (out_acc && !in_acc) begin
            pend_reg <= pend_reg - 4'd1;
        end
    end

    a_resp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_result_value))
        else $error("response changed while stalled");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> pend_reg != 4'd0)
        else $error("response without a pending request");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= 4'd5)
        else $error("more requests in flight than the pipeline holds");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_ABSENT || m_status == ST_FULL) |-> m_result_value == '0)
        else $error("miss or full response carries data");

    a_clear_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_ready)
        else $error("request taken before bucket heads are cleared");

endmodule

bind u64_key_hash_table_core u64ht_checker u_chk (.*);

### sim/u64_key_hash_table_core_tb.sv
// Self-checking testbench for the 64-bit key hash table core.
`timescale 1ns / 1ps
module u64_key_hash_table_core_tb;
    import u64ht_pkg::*;

    localparam int NBKT = MAX_BUCKETS_DEF;
    localparam int NPOOL = POOL_NODES_DEF;
    localparam int NIL = NPOOL;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  val;
        bit                typed;
        logic [STAT_W-1:0] est;
        logic [VAL_W-1:0]  erv;
    } dir_row_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  rv;
    } resp_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_bucket_count = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [ACT_W-1:0]    s_action = '0;
    logic [KEY_W-1:0]    s_key = '0;
    logic [VAL_W-1:0]    s_value = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STAT_W-1:0]   m_status;
    logic [VAL_W-1:0]    m_result_value;

    // shadow table
    int               tbl_heads [NBKT];
    logic [KEY_W-1:0] tbl_keys [NPOOL];
    logic [VAL_W-1:0] tbl_vals [NPOOL];
    int               tbl_links [NPOOL];
    int               tbl_free;
    logic [CFG_W-1:0] tbl_bcount;

    resp_t            pending_resp [$];
    logic [KEY_W-1:0] used_keys [$];
    dir_row_t         dir_rows [20];
    int               n_errors = 0;
    int               cycles = 0;
    bit               idle_en = 1'b1;
    bit               hold_go = 1'b0;
    int               hold_left = 0;
    int               stall_left = 0;

    u64_key_hash_table_core i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_bucket_count (cfg_bucket_count),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_key            (s_key),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_result_value   (m_result_value)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        $display("MISMATCH %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
    endtask

    task automatic table_reset();
        for (int i = 0; i < NBKT; i++) tbl_heads[i] = NIL;
        for (int i = 0; i < NPOOL; i++) begin
            tbl_keys[i] = '0;
            tbl_vals[i] = '0;
            tbl_links[i] = i + 1;
        end
        tbl_free = 0;
        tbl_bcount = BUCKET_COUNT_RST;
    endtask

    // Works out the response of one request and updates the shadow table.
    task automatic table_apply(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] val, output resp_t r);
        int  nb;
        int  b;
        int  p;
        int  c;
        int  steps;
        int  nd;
        bit  hit;
        nb = (tbl_bcount == 0) ? 1 : (tbl_bcount > NBKT) ? NBKT : int'(tbl_bcount);
        b = int'(key % 64'(nb));
        p = NIL;
        c = tbl_heads[b];
        steps = 0;
        hit = 1'b0;
        while (c < NIL && steps < NPOOL) begin
            if (tbl_keys[c] == key) begin
                hit = 1'b1;
                break;
            end
            if (key < tbl_keys[c]) break;
            p = c;
            c = tbl_links[c];
            steps++;
        end
        if (!hit && (c >= NIL || steps >= NPOOL)) c = NIL;
        r.status = ST_ABSENT;
        r.rv = '0;
        case (act)
            ACT_INSERT: begin
                if (hit) begin
                    r.rv = tbl_vals[c];
                    tbl_vals[c] = val;
                    r.status = ST_FOUND;
                end else if (tbl_free >= NIL) begin
                    r.status = ST_FULL;
                end else begin
                    nd = tbl_free;
                    tbl_free = tbl_links[nd];
                    tbl_keys[nd] = key;
                    tbl_vals[nd] = val;
                    tbl_links[nd] = c;
                    if (p < NIL) tbl_links[p] = nd;
                    else tbl_heads[b] = nd;
                    r.status = ST_NEW;
                    r.rv = val;
                end
            end
            ACT_LOOKUP: begin
                if (hit) begin
                    r.status = ST_FOUND;
                    r.rv = tbl_vals[c];
                end
            end
            ACT_DELETE: begin
                if (hit) begin
                    r.rv = tbl_vals[c];
                    if (p < NIL) tbl_links[p] = tbl_links[c];
                    else tbl_heads[b] = tbl_links[c];
                    tbl_links[c] = tbl_free;
                    tbl_free = c;
                    r.status = ST_FOUND;
                end
            end
            default: ;
        endcase
    endtask

    // Offers one request, waits for it to be taken, then records the expected response.
    task automatic send_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] val, input bit typed,
                                input resp_t typed_r);
        resp_t r;
        s_valid <= 1'b1;
        s_action <= act;
        s_key <= key;
        s_value <= val;
        do @(posedge aclk); while (!s_ready);
        table_apply(act, key, val, r);
        pending_resp.push_back(typed ? typed_r : r);
        if (act == ACT_INSERT && r.status == ST_NEW && used_keys.size() < 3000)
            used_keys.push_back(key);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge aclk);
    endtask

    task automatic write_buckets(input logic [CFG_W-1:0] v);
        drain();
        repeat (20) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_bucket_count <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tbl_bcount = v;
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input int fresh_pct, input int span);
        if (used_keys.size() != 0 && $urandom_range(0, 99) >= fresh_pct)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        if (span > 0) return KEY_W'($urandom_range(0, span - 1));
        return {$urandom, $urandom};
    endfunction

    // Mixed traffic; noise means the occasional unused action code.
    task automatic random_requests(input int n, input int ins_pct, input int del_pct,
                                   input int fresh_pct, input int span);
        int             roll;
        logic [ACT_W-1:0] act;
        resp_t          none;
        none = '{default: '0};
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct) act = ACT_INSERT;
            else if (roll < ins_pct + del_pct) act = ACT_DELETE;
            else if (roll < 98) act = ACT_LOOKUP;
            else act = ACT_UNUSED;
            send_request(act, pick_key(fresh_pct, span), $urandom, 1'b0, none);
        end
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // response side: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (hold_go) begin
            hold_go = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        resp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_resp.size() == 0) begin
                report_mismatch("unexpected response", m_status, 0);
            end else begin
                want = pending_resp.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_result_value !== want.rv)
                    report_mismatch("result_value", m_result_value, want.rv);
            end
        end
    end

    initial begin
        resp_t tr;
        dir_rows = '{
            '{ACT_LOOKUP, 64'd0, 32'd0, 1, ST_ABSENT, 32'd0},
            '{ACT_DELETE, 64'd0, 32'd7, 1, ST_ABSENT, 32'd0},
            '{ACT_INSERT, 64'd0, 32'd0, 1, ST_NEW, 32'd0},
            '{ACT_INSERT, 64'd0, 32'hFFFF_FFFF, 1, ST_FOUND, 32'd0},
            '{ACT_LOOKUP, 64'd0, 32'd0, 1, ST_FOUND, 32'hFFFF_FFFF},
            '{ACT_INSERT, '1, 32'hA5A5_A5A5, 1, ST_NEW, 32'hA5A5_A5A5},
            '{ACT_INSERT, 64'd256, 32'd1, 1, ST_NEW, 32'd1},
            '{ACT_INSERT, 64'd768, 32'd3, 1, ST_NEW, 32'd3},
            '{ACT_INSERT, 64'd512, 32'd2, 1, ST_NEW, 32'd2},
            '{ACT_LOOKUP, 64'd512, 32'd0, 0, ST_FOUND, 32'd0},
            '{ACT_LOOKUP, 64'd1024, 32'd0, 1, ST_ABSENT, 32'd0},
            '{ACT_DELETE, 64'd512, 32'd0, 1, ST_FOUND, 32'd2},
            '{ACT_LOOKUP, 64'd768, 32'd0, 0, ST_FOUND, 32'd0},
            '{ACT_LOOKUP, 64'd512, 32'd0, 1, ST_ABSENT, 32'd0},
            '{ACT_UNUSED, 64'd256, 32'd9, 1, ST_ABSENT, 32'd0},
            '{ACT_LOOKUP, 64'd256, 32'd0, 0, ST_FOUND, 32'd0},
            '{ACT_DELETE, 64'd0, 32'd0, 1, ST_FOUND, 32'hFFFF_FFFF},
            '{ACT_DELETE, '1, 32'd0, 1, ST_FOUND, 32'hA5A5_A5A5},
            '{ACT_INSERT, 64'h5555_5555_5555_5555, 32'h5A5A_5A5A, 0, ST_NEW, 32'd0},
            '{ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0F0F_F0F0, 0, ST_NEW, 32'd0}
        };
        table_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            tr.status = dir_rows[i].est;
            tr.rv = dir_rows[i].erv;
            send_request(dir_rows[i].act, dir_rows[i].key, dir_rows[i].val,
                         dir_rows[i].typed, tr);
        end

        // one bucket (0 acts as 1), small key space: long sorted chains
        write_buckets(9'd0);
        random_requests(150, 45, 25, 40, 32);

        // above range acts as full width; fill the pool past exhaustion
        write_buckets(9'h1FF);
        hold_go = 1'b1;
        random_requests(1040, 100, 0, 100, 0);
        random_requests(40, 60, 0, 30, 0);

        write_buckets(9'd7);
        random_requests(300, 25, 50, 10, 0);

        write_buckets(9'd1);
        write_buckets(9'($urandom_range(2, 256)));
        idle_en = 1'b0;
        random_requests(100, 40, 30, 40, 0);

        drain();
        repeat (200) @(posedge aclk);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
